@@ hdl/bitmap_set_bit_enumerator_top_defines.svh @@
// Assertion macros for the bitmap set-bit enumerator.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef BITMAP_SET_BIT_ENUMERATOR_TOP_DEFINES_SVH
`define BITMAP_SET_BIT_ENUMERATOR_TOP_DEFINES_SVH

// Checked only while out of reset.
`define BSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define BSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hdl/bse_pkg.sv @@
// Shared types and constants for the bitmap set-bit enumerator.
// No dependencies.
package bse_pkg;

    localparam int NUM_WORDS = 64;
    localparam int DATA_W    = 32;
    localparam int BIT_AW    = 5;
    localparam int WORD_AW   = $clog2(NUM_WORDS);
    localparam int CNT_W     = $clog2(NUM_WORDS + 1);
    localparam int POS_W     = 11;
    localparam int KIND_W    = 3;
    localparam int WIDX_W    = 6;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET_BIT   = 3'd0,
        KIND_CLEAR_BIT = 3'd1,
        KIND_CLEAR_ALL = 3'd2,
        KIND_LOAD_WORD = 3'd3,
        KIND_BEGIN     = 3'd4,
        KIND_ADVANCE   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RMW,
        ST_SCAN,
        ST_OUT
    } state_t;

    // Write side of the bitmap store.
    typedef struct packed {
        logic               clear_all;
        logic               en;
        logic [WORD_AW-1:0] addr;
        logic [DATA_W-1:0]  data;
    } mem_wr_t;

endpackage

@@ hdl/bitmap_set_bit_enumerator_top.sv @@
// Bitmap of 32-bit words with a set-bit enumerator, sequenced over one word store.
// Clear all, load word, flagged or unused kinds and clear bit beyond the used words go from
// execute straight to the result; set and clear bit add a read-modify-write step first.
// Begin and advance scan the used words, one word per cycle, until a set bit or the end; an
// advance with no active enumeration goes straight to the result. One item at a time.
// Synchronous active-low reset empties the map at once.
`include "bitmap_set_bit_enumerator_top_defines.svh"

module bitmap_set_bit_enumerator_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bse_pkg::KIND_W-1:0]   s_kind,
    input  logic [bse_pkg::POS_W-1:0]    s_bit_index,
    input  logic [bse_pkg::WIDX_W-1:0]   s_word_index,
    input  logic [bse_pkg::DATA_W-1:0]   s_word_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic [bse_pkg::POS_W-1:0]    m_position,
    output logic                         m_bad_index
);
    import bse_pkg::*;

    function automatic logic [BIT_AW-1:0] lowest_bit(input logic [DATA_W-1:0] w);
        logic [BIT_AW-1:0] b;
        b = BIT_AW'(DATA_W - 1);
        for (int i = DATA_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                b = BIT_AW'(i);
            end
        end
        return b;
    endfunction

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [WORD_AW-1:0]   scan_word_reg, scan_word_next;
    logic [BIT_AW-1:0]    scan_bit_reg, scan_bit_next;
    logic                 enum_active_reg, enum_active_next;

    kind_t                kind_reg, kind_next;
    logic [POS_W-1:0]     bidx_reg, bidx_next;
    logic [WIDX_W-1:0]    widx_reg, widx_next;
    logic [DATA_W-1:0]    data_reg, data_next;
    logic [CNT_W-1:0]     cur_reg, cur_next;
    logic                 first_reg, first_next;
    logic                 found_reg, found_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 bad_reg, bad_next;

    mem_wr_t              wr;
    logic [WORD_AW-1:0]   rd_addr;
    logic [DATA_W-1:0]    rd_data;

    logic [WORD_AW-1:0]   bit_word;
    logic [DATA_W-1:0]    bit_mask;
    logic [DATA_W-1:0]    above_mask;
    logic [DATA_W-1:0]    masked;
    logic [BIT_AW-1:0]    low_bit;
    logic [CNT_W-1:0]     cur_inc;

    bse_bitmap_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign bit_word   = bidx_reg[POS_W-1:BIT_AW];
    assign bit_mask   = DATA_W'(1) << bidx_reg[BIT_AW-1:0];
    // Bits strictly above the last reported one; empty when it was bit 31.
    assign above_mask = ({DATA_W{1'b1}} << scan_bit_reg) << 1;
    assign masked     = rd_data & (first_reg ? above_mask : {DATA_W{1'b1}});
    assign low_bit    = lowest_bit(masked);
    assign cur_inc    = cur_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            used_reg        <= '0;
            scan_word_reg   <= '0;
            scan_bit_reg    <= '0;
            enum_active_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            scan_word_reg   <= scan_word_next;
            scan_bit_reg    <= scan_bit_next;
            enum_active_reg <= enum_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        bidx_reg  <= bidx_next;
        widx_reg  <= widx_next;
        data_reg  <= data_next;
        cur_reg   <= cur_next;
        first_reg <= first_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        bad_reg   <= bad_next;
    end

    always_comb begin
        state_next       = state_reg;
        used_next        = used_reg;
        scan_word_next   = scan_word_reg;
        scan_bit_next    = scan_bit_reg;
        enum_active_next = enum_active_reg;
        kind_next        = kind_reg;
        bidx_next        = bidx_reg;
        widx_next        = widx_reg;
        data_next        = data_reg;
        cur_next         = cur_reg;
        first_next       = first_reg;
        found_next       = found_reg;
        pos_next         = pos_reg;
        bad_next         = bad_reg;
        wr               = '0;
        rd_addr          = '0;
        s_ready          = 1'b0;
        m_valid          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next  = kind_t'(s_kind);
                    bidx_next  = s_bit_index;
                    widx_next  = s_word_index;
                    data_next  = s_word_data;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                found_next = 1'b0;
                pos_next   = '0;
                bad_next   = 1'b0;
                state_next = ST_OUT;
                unique case (kind_reg)
                    KIND_SET_BIT: begin
                        if (CNT_W'(bit_word) >= CNT_W'(NUM_WORDS)) begin
                            bad_next = 1'b1;
                        end else begin
                            rd_addr    = bit_word;
                            state_next = ST_RMW;
                        end
                    end
                    KIND_CLEAR_BIT: begin
                        if (CNT_W'(bit_word) >= CNT_W'(NUM_WORDS)) begin
                            bad_next = 1'b1;
                        end else if (CNT_W'(bit_word) < used_reg) begin
                            rd_addr    = bit_word;
                            state_next = ST_RMW;
                        end
                    end
                    KIND_CLEAR_ALL: begin
                        wr.clear_all = 1'b1;
                    end
                    KIND_LOAD_WORD: begin
                        if (CNT_W'(widx_reg) >= CNT_W'(NUM_WORDS)) begin
                            bad_next = 1'b1;
                        end else begin
                            wr.en   = 1'b1;
                            wr.addr = WORD_AW'(widx_reg);
                            wr.data = data_reg;
                            if (CNT_W'(widx_reg) >= used_reg) begin
                                used_next = CNT_W'(widx_reg) + CNT_W'(1);
                            end
                        end
                    end
                    KIND_BEGIN: begin
                        cur_next   = '0;
                        first_next = 1'b0;
                        rd_addr    = '0;
                        state_next = ST_SCAN;
                    end
                    KIND_ADVANCE: begin
                        if (enum_active_reg) begin
                            cur_next   = CNT_W'(scan_word_reg);
                            first_next = 1'b1;
                            rd_addr    = scan_word_reg;
                            state_next = ST_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ST_RMW: begin
                wr.en      = 1'b1;
                wr.addr    = bit_word;
                state_next = ST_OUT;
                if (kind_reg == KIND_SET_BIT) begin
                    wr.data = rd_data | bit_mask;
                    if (CNT_W'(bit_word) >= used_reg) begin
                        used_next = CNT_W'(bit_word) + CNT_W'(1);
                    end
                end else begin
                    wr.data = rd_data & ~bit_mask;
                end
            end

            ST_SCAN: begin
                if (cur_reg >= used_reg) begin
                    enum_active_next = 1'b0;
                    found_next       = 1'b0;
                    pos_next         = '0;
                    state_next       = ST_OUT;
                end else if (masked != '0) begin
                    enum_active_next = 1'b1;
                    scan_word_next   = cur_reg[WORD_AW-1:0];
                    scan_bit_next    = low_bit;
                    found_next       = 1'b1;
                    pos_next         = POS_W'({cur_reg[WORD_AW-1:0], low_bit});
                    state_next       = ST_OUT;
                end else begin
                    // advance to the next word, its read issued this cycle
                    cur_next   = cur_inc;
                    first_next = 1'b0;
                    rd_addr    = cur_inc[WORD_AW-1:0];
                end
            end

            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_found     = found_reg;
    assign m_position  = pos_reg;
    assign m_bad_index = bad_reg;

    `BSE_ASSERT(a_one_side_open, !(s_ready && m_valid), "input and result open together")
    `BSE_ASSERT(a_transfer_starts_work, (s_valid && s_ready) |=> (state_reg == ST_EXEC), "transfer did not start work")
    `BSE_ASSERT(a_used_bounded, used_reg <= CNT_W'(NUM_WORDS), "used word count overflow")
    `BSE_ASSERT(a_scan_in_range, enum_active_reg |-> (CNT_W'(scan_word_reg) < used_reg), "enumerator past used words")

endmodule

@@ hdl/bse_bitmap_mem.sv @@
// Bitmap word store: one write port, one registered read port.
// Per-word valid bits make unwritten words read as zero. Depends on bse_pkg.
module bse_bitmap_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bse_pkg::mem_wr_t              wr,
    input  logic [bse_pkg::WORD_AW-1:0]   rd_addr,
    output logic [bse_pkg::DATA_W-1:0]    rd_data
);
    import bse_pkg::*;

    logic [DATA_W-1:0]    mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] valid_reg;
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr.clear_all) begin
                valid_reg <= '0;
            end else if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
